// File: src/idt_pkg.sv
// ----------------------------------------------------------------------------
// idt_pkg
// shared types and constants of the indent/dedent token generator
// ----------------------------------------------------------------------------
package idt_pkg;

  localparam int unsigned LEVEL_W           = 16;
  localparam int unsigned DEPTH_OUT_W       = 9;
  localparam int unsigned DEF_STACK_DEPTH   = 256;

  typedef enum logic [1:0] {
    TOK_NONE    = 2'd0,
    TOK_NEWLINE = 2'd1,
    TOK_INDENT  = 2'd2,
    TOK_DEDENT  = 2'd3
  } tok_kind_e;

  typedef enum logic [1:0] {
    STK_HOLD,
    STK_PUSH,
    STK_POP
  } stk_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_WALK
  } state_e;

  typedef struct packed {
    logic               accept_newline;
    logic               accept_indent;
    logic               accept_dedent;
    logic               at_end;
    logic [LEVEL_W-1:0] indent_width;
    logic               line_is_empty;
    logic               break_at_start;
    logic               break_after_indent;
  } req_t;

  typedef struct packed {
    logic [1:0]             token_kind;
    logic [DEPTH_OUT_W-1:0] nesting_depth;
  } rsp_t;

  typedef struct packed {
    stk_op_e            op;
    logic [LEVEL_W-1:0] push_level;
  } stk_ctrl_t;

endpackage

// File: src/idt_stream_if.sv
// ----------------------------------------------------------------------------
// idt_stream_if
// valid/ready channel carrying one word of type T
// ----------------------------------------------------------------------------
interface idt_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: src/indent_dedent_tokenizer.sv
// ----------------------------------------------------------------------------
// indent_dedent_tokenizer
// offside-rule layout token generator with a shifting indent level stack
//
//   channel   dir   word    content
//   req_i     in    req_t   token request and measured line facts
//   rsp_o     out   rsp_t   token kind and nesting depth
//
// a request is accepted in ST_IDLE, then decided in ST_EVAL or ST_WALK, which loads the output register
// a dedent that drops n levels walks the stack in ST_WALK: one cell shift per level,
// then the step that loads the first dedent word
// a new request is taken once the previous one has moved into the output register
// reset clears the stack to the single base level zero
// a stalled output holds the decision until the register drains
// ----------------------------------------------------------------------------
module indent_dedent_tokenizer
  import idt_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = DEF_STACK_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  idt_stream_if.sink          req_i,
  idt_stream_if.source        rsp_o
);

  localparam int unsigned CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned OWED_W = $clog2(STACK_DEPTH);

  state_e              state_q, state_d;
  req_t                req_q;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [OWED_W-1:0]   owed_q, owed_d;
  logic                ls_q, ls_d;
  logic                rsp_valid_q;
  rsp_t                rsp_q;

  logic                emit;
  logic                walk;
  tok_kind_e           tok;
  stk_op_e             op;
  logic                out_free;
  logic                commit;
  logic                examined;
  logic                brk;
  logic [LEVEL_W-1:0]  top;
  logic [31:0]         cnt_ext;
  stk_ctrl_t           stk_ctrl;

  assign out_free = !rsp_valid_q || rsp_o.ready;
  assign commit   = (state_q != ST_IDLE) && (!emit || out_free);

  // decision for the current request
  always_comb begin
    emit     = 1'b0;
    walk     = 1'b0;
    tok      = TOK_NONE;
    op       = STK_HOLD;
    cnt_d    = cnt_q;
    owed_d   = owed_q;
    ls_d     = ls_q;
    examined = 1'b0;
    brk      = 1'b0;
    case (state_q)
      ST_EVAL: begin
        emit = 1'b1;
        if (req_q.accept_dedent && (owed_q != '0)) begin
          tok    = TOK_DEDENT;
          owed_d = owed_q - OWED_W'(1);
        end else if (req_q.at_end) begin
          if (req_q.accept_dedent && (cnt_q > CNT_W'(1))) begin
            tok   = TOK_DEDENT;
            op    = STK_POP;
            cnt_d = cnt_q - CNT_W'(1);
          end else if (req_q.accept_newline && !ls_q) begin
            tok  = TOK_NEWLINE;
            ls_d = 1'b1;
          end
        end else begin
          examined = ls_q && (req_q.accept_indent || req_q.accept_dedent);
          brk      = examined ? req_q.break_after_indent : req_q.break_at_start;
          if (examined && !req_q.line_is_empty && (req_q.indent_width > top)
              && req_q.accept_indent) begin
            tok  = TOK_INDENT;
            ls_d = 1'b0;
            if (cnt_q < CNT_W'(STACK_DEPTH)) begin
              op    = STK_PUSH;
              cnt_d = cnt_q + CNT_W'(1);
            end
          end else if (examined && !req_q.line_is_empty
                       && (req_q.indent_width < top) && req_q.accept_dedent) begin
            emit = 1'b0;
            walk = 1'b1;
          end else if (req_q.accept_newline && brk) begin
            tok  = TOK_NEWLINE;
            ls_d = 1'b1;
          end else begin
            ls_d = 1'b0;
          end
        end
      end
      ST_WALK: begin
        if ((cnt_q > CNT_W'(1)) && (req_q.indent_width < top)) begin
          op     = STK_POP;
          cnt_d  = cnt_q - CNT_W'(1);
          owed_d = owed_q + OWED_W'(1);
        end else begin
          emit   = 1'b1;
          tok    = TOK_DEDENT;
          owed_d = owed_q - OWED_W'(1);
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (walk) begin
          state_d = ST_WALK;
        end else if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_WALK: begin
        if (emit && out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // fsm outputs
  always_comb begin
    req_i.ready         = (state_q == ST_IDLE);
    stk_ctrl.op         = commit ? op : STK_HOLD;
    stk_ctrl.push_level = req_q.indent_width;
  end

  assign cnt_ext = 32'(cnt_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= CNT_W'(1);
      owed_q      <= '0;
      ls_q        <= 1'b1;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (commit) begin
        cnt_q  <= cnt_d;
        owed_q <= owed_d;
        ls_q   <= ls_d;
      end
      if (commit && emit) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      req_q <= req_i.data;
    end
    if (commit && emit) begin
      rsp_q.token_kind    <= tok;
      rsp_q.nesting_depth <= cnt_ext[DEPTH_OUT_W-1:0];
    end
  end

  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

  idt_stack #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (stk_ctrl),
    .top_o  (top)
  );

endmodule

// File: src/idt_cell.sv
// ----------------------------------------------------------------------------
// idt_cell
// one entry of the shifting level stack
// ----------------------------------------------------------------------------
module idt_cell
  import idt_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  stk_op_e            op_i,
  input  logic [LEVEL_W-1:0] left_i,
  input  logic [LEVEL_W-1:0] right_i,
  output logic [LEVEL_W-1:0] level_o
);

  logic [LEVEL_W-1:0] level_q;
  logic [LEVEL_W-1:0] level_d;

  always_comb begin
    case (op_i)
      STK_PUSH: level_d = left_i;
      STK_POP:  level_d = right_i;
      default:  level_d = level_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
    end else begin
      level_q <= level_d;
    end
  end

  assign level_o = level_q;

endmodule

// File: src/idt_stack.sv
// ----------------------------------------------------------------------------
// idt_stack
// row of cells, top of stack in cell zero, push shifts down, pop shifts up
// ----------------------------------------------------------------------------
module idt_stack
  import idt_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = DEF_STACK_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  stk_ctrl_t          ctrl_i,
  output logic [LEVEL_W-1:0] top_o
);

  logic [LEVEL_W-1:0] level [STACK_DEPTH];

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [LEVEL_W-1:0] left;
    logic [LEVEL_W-1:0] right;

    if (i == 0) begin : g_first
      assign left = ctrl_i.push_level;
    end else begin : g_mid
      assign left = level[i-1];
    end

    if (i == STACK_DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_inner
      assign right = level[i+1];
    end

    idt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .op_i    (ctrl_i.op),
      .left_i  (left),
      .right_i (right),
      .level_o (level[i])
    );
  end

  assign top_o = level[0];

endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the indent/dedent layout token generator
//
// token requests run through a valid/ready driver fed from a request queue,
// and a clocked monitor checks each response word against a software copy of
// the level stack, owed dedents and line-start flag. a short directed part
// covers indent, dedent, empty lines, end of input and uneven dedents. a
// climb fills the level stack. random well-formed lines, end-of-input runs
// and noise follow. both channels idle in phases: none, sender only,
// receiver only, then both.
// ----------------------------------------------------------------------------
module testbench
  import idt_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STACK_DEPTH = DEF_STACK_DEPTH;
  localparam int unsigned NUM_REQS    = 1400;

  logic clk_i;
  logic rst_ni;

  idt_stream_if #(.T(req_t)) req_ch ();
  idt_stream_if #(.T(rsp_t)) rsp_ch ();

  indent_dedent_tokenizer #(
    .STACK_DEPTH(STACK_DEPTH)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_ch),
    .rsp_o (rsp_ch)
  );

  req_t        token_requests[$];
  rsp_t        expected_tokens[$];
  int unsigned total_reqs;
  int unsigned words_sent;
  int unsigned error_count;

  logic [LEVEL_W-1:0] levels [STACK_DEPTH];
  int unsigned        level_count;
  int unsigned        owed_dedents;
  bit                 line_fresh;

  function automatic rsp_t next_layout_token(req_t r);
    rsp_t               res;
    tok_kind_e          kind;
    bit                 examined;
    bit                 decided;
    logic [LEVEL_W-1:0] top;
    kind     = TOK_NONE;
    examined = 1'b0;
    decided  = 1'b0;
    if (r.accept_dedent && owed_dedents > 0) begin
      owed_dedents--;
      kind = TOK_DEDENT;
    end else if (r.at_end) begin
      if (r.accept_dedent && level_count > 1) begin
        level_count--;
        kind = TOK_DEDENT;
      end else if (r.accept_newline && !line_fresh) begin
        line_fresh = 1'b1;
        kind       = TOK_NEWLINE;
      end
    end else begin
      if (line_fresh && (r.accept_indent || r.accept_dedent)) begin
        examined = 1'b1;
        if (!r.line_is_empty) begin
          top = levels[level_count-1];
          if (r.indent_width > top && r.accept_indent) begin
            if (level_count < STACK_DEPTH) begin
              levels[level_count] = r.indent_width;
              level_count++;
            end
            line_fresh = 1'b0;
            kind       = TOK_INDENT;
            decided    = 1'b1;
          end else begin
            if (r.indent_width < top && r.accept_dedent) begin
              while (level_count > 1 && r.indent_width < levels[level_count-1]) begin
                level_count--;
                owed_dedents++;
              end
              if (owed_dedents > 0) begin
                owed_dedents--;
                kind    = TOK_DEDENT;
                decided = 1'b1;
              end
            end
            if (!decided) line_fresh = 1'b0;
          end
        end
      end
      if (!decided) begin
        if (r.accept_newline && (examined ? r.break_after_indent : r.break_at_start)) begin
          line_fresh = 1'b1;
          kind       = TOK_NEWLINE;
        end else begin
          line_fresh = 1'b0;
        end
      end
    end
    res.token_kind    = kind;
    res.nesting_depth = level_count[DEPTH_OUT_W-1:0];
    return res;
  endfunction

  function automatic req_t mk_req(bit nl, bit ind, bit ded, bit eoi,
                                  logic [LEVEL_W-1:0] w, bit empty, bit bs, bit ba);
    req_t r;
    r.accept_newline     = nl;
    r.accept_indent      = ind;
    r.accept_dedent      = ded;
    r.at_end             = eoi;
    r.indent_width       = w;
    r.line_is_empty      = empty;
    r.break_at_start     = bs;
    r.break_after_indent = ba;
    return r;
  endfunction

  function automatic logic [LEVEL_W-1:0] pick_width();
    int unsigned sel;
    sel = $urandom_range(15);
    if (sel < 12) return LEVEL_W'(4 * $urandom_range(10));
    else if (sel < 14) return LEVEL_W'($urandom_range(48));
    else if (sel == 14) return LEVEL_W'($urandom_range(65535));
    else return $urandom_range(1) ? '1 : '0;
  endfunction

  // one source line: line-start request, repeats while dedents drain,
  // content tokens, then the line break
  task automatic add_line();
    req_t        r;
    int unsigned n;
    r = mk_req(1'($urandom_range(1)), $urandom_range(9) != 0, $urandom_range(9) != 0,
               1'b0, pick_width(), $urandom_range(7) == 0, $urandom_range(3) == 0, 1'b0);
    r.break_after_indent = r.line_is_empty | ($urandom_range(3) == 0);
    n = $urandom_range(4);
    repeat (n + 1) token_requests.push_back(r);
    n = $urandom_range(3);
    repeat (n) token_requests.push_back(mk_req($urandom_range(3) == 0, 1'b0, 1'b0, 1'b0,
                                               pick_width(), 1'b0, 1'b0, 1'b0));
    token_requests.push_back(mk_req(1'b1, 1'b0, 1'($urandom_range(1)), 1'b0,
                                    pick_width(), 1'b0, 1'b1, 1'($urandom_range(1))));
  endtask

  task automatic add_eof_run();
    int unsigned n;
    n = $urandom_range(6, 1);
    repeat (n) token_requests.push_back(mk_req(1'($urandom_range(1)),
                                               1'($urandom_range(1)),
                                               $urandom_range(4) != 0, 1'b1, pick_width(),
                                               1'($urandom_range(1)),
                                               1'($urandom_range(1)),
                                               1'($urandom_range(1))));
  endtask

  task automatic add_noise();
    logic [31:0] bits;
    bits = $urandom;
    token_requests.push_back(bits[$bits(req_t)-1:0]);
  endtask

  task automatic note_error(string msg);
    if (error_count < 10) $display("%s", msg);
    error_count++;
  endtask

  function automatic int unsigned idle_phase();
    return (total_reqs == 0) ? 0 : (words_sent * 4) / total_reqs;
  endfunction

  function automatic int unsigned sender_idle_pct();
    case (idle_phase())
      1:       return 51;
      3:       return 19;
      default: return 0;
    endcase
  endfunction

  function automatic int unsigned receiver_stall_pct();
    case (idle_phase())
      2:       return 51;
      3:       return 19;
      default: return 0;
    endcase
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_ch.valid && req_ch.ready) begin
        expected_tokens.push_back(next_layout_token(req_ch.data));
        words_sent++;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (token_requests.size() > 0 && $urandom_range(99) >= sender_idle_pct()) begin
          req_ch.valid <= 1'b1;
          req_ch.data  <= token_requests.pop_front();
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_tokens.size() == 0) begin
          note_error($sformatf("unexpected word: kind %0d depth %0d",
                               rsp_ch.data.token_kind, rsp_ch.data.nesting_depth));
        end else begin
          want = expected_tokens.pop_front();
          if (rsp_ch.data.token_kind !== want.token_kind)
            note_error($sformatf("token_kind: expected %0d, got %0d",
                                 want.token_kind, rsp_ch.data.token_kind));
          if (rsp_ch.data.nesting_depth !== want.nesting_depth)
            note_error($sformatf("nesting_depth: expected %0d, got %0d",
                                 want.nesting_depth, rsp_ch.data.nesting_depth));
        end
      end
      rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct());
    end
  end

  initial begin
    int unsigned sel;
    rst_ni       = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    rsp_ch.ready = 1'b0;
    words_sent   = 0;
    total_reqs   = 0;
    error_count  = 0;
    foreach (levels[i]) levels[i] = '0;
    level_count  = 1;
    owed_dedents = 0;
    line_fresh   = 1'b1;

    // directed
    token_requests.push_back(mk_req(1'b1, 1'b0, 1'b0, 1'b0, 16'd0,    1'b0, 1'b1, 1'b0));
    token_requests.push_back(mk_req(1'b1, 1'b1, 1'b1, 1'b0, 16'd4,    1'b0, 1'b0, 1'b0));
    token_requests.push_back(mk_req(1'b0, 1'b0, 1'b0, 1'b0, 16'd0,    1'b0, 1'b0, 1'b0));
    token_requests.push_back(mk_req(1'b1, 1'b0, 1'b0, 1'b0, 16'd0,    1'b0, 1'b1, 1'b0));
    token_requests.push_back(mk_req(1'b1, 1'b1, 1'b1, 1'b0, 16'd0,    1'b1, 1'b0, 1'b1));
    token_requests.push_back(mk_req(1'b1, 1'b1, 1'b0, 1'b0, 16'd8,    1'b0, 1'b0, 1'b0));
    token_requests.push_back(mk_req(1'b1, 1'b0, 1'b0, 1'b0, 16'd0,    1'b0, 1'b1, 1'b1));
    token_requests.push_back(mk_req(1'b0, 1'b1, 1'b1, 1'b0, 16'hffff, 1'b0, 1'b1, 1'b1));
    token_requests.push_back(mk_req(1'b1, 1'b0, 1'b0, 1'b0, 16'hffff, 1'b0, 1'b1, 1'b0));
    token_requests.push_back(mk_req(1'b1, 1'b1, 1'b1, 1'b0, 16'd6,    1'b0, 1'b1, 1'b1));
    token_requests.push_back(mk_req(1'b1, 1'b1, 1'b1, 1'b0, 16'd6,    1'b0, 1'b1, 1'b1));
    token_requests.push_back(mk_req(1'b1, 1'b1, 1'b1, 1'b0, 16'd6,    1'b0, 1'b1, 1'b1));
    token_requests.push_back(mk_req(1'b1, 1'b0, 1'b0, 1'b0, 16'd0,    1'b0, 1'b1, 1'b0));
    token_requests.push_back(mk_req(1'b1, 1'b1, 1'b1, 1'b0, 16'd6,    1'b0, 1'b0, 1'b1));
    token_requests.push_back(mk_req(1'b1, 1'b0, 1'b1, 1'b0, 16'd99,   1'b0, 1'b0, 1'b1));
    token_requests.push_back(mk_req(1'b0, 1'b1, 1'b0, 1'b0, 16'd0,    1'b0, 1'b0, 1'b0));
    token_requests.push_back(mk_req(1'b1, 1'b1, 1'b1, 1'b1, 16'd0,    1'b0, 1'b1, 1'b1));
    token_requests.push_back(mk_req(1'b1, 1'b1, 1'b1, 1'b1, 16'd0,    1'b0, 1'b1, 1'b1));
    token_requests.push_back(mk_req(1'b0, 1'b0, 1'b1, 1'b1, 16'd0,    1'b0, 1'b0, 1'b0));
    token_requests.push_back(mk_req(1'b1, 1'b0, 1'b1, 1'b1, 16'd0,    1'b0, 1'b0, 1'b0));
    token_requests.push_back(mk_req(1'b1, 1'b0, 1'b1, 1'b1, 16'd0,    1'b0, 1'b0, 1'b0));
    token_requests.push_back(mk_req(1'b1, 1'b1, 1'b1, 1'b0, 16'd0,    1'b0, 1'b1, 1'b0));
    token_requests.push_back(mk_req(1'b1, 1'b0, 1'b1, 1'b0, 16'd12,   1'b0, 1'b1, 1'b1));

    // climb past the top of the level stack
    for (int k = 0; k < STACK_DEPTH + 4; k++) begin
      token_requests.push_back(mk_req(1'b1, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 1'b1, 1'b1));
      token_requests.push_back(mk_req(1'b0, 1'b1, 1'b0, 1'b0, LEVEL_W'(100 + 8 * k),
                                      1'b0, 1'b0, 1'b0));
    end

    while (token_requests.size() < NUM_REQS) begin
      sel = $urandom_range(99);
      if (sel < 78) add_line();
      else if (sel < 88) add_eof_run();
      else add_noise();
    end
    total_reqs = token_requests.size();

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (token_requests.size() > 0 || req_ch.valid) @(posedge clk_i);
    while (expected_tokens.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("[indent_dedent_tokenizer] OK");
    end else begin
      $display("[indent_dedent_tokenizer] ERROR");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("[indent_dedent_tokenizer] ERROR");
    $finish;
  end

endmodule
